>>> hdl/aarh_pkg.sv
// ----------------------------------------------------------------------------
// aarh_pkg
// Types and constants shared by the ray versus rectangle hit test.
// ----------------------------------------------------------------------------
package aarh_pkg;

  localparam int FRAC_BITS = 16;
  localparam int UV_BITS   = 16;
  // Divider: numerator magnitude and divisor magnitude widths.
  localparam int DIV_NW    = 33 + FRAC_BITS;
  localparam int DIV_DW    = 33;
  localparam int DIV_LAT   = DIV_NW;
  localparam int T_W       = DIV_NW + 1;
  localparam int PT_W      = 49;

  typedef enum logic [1:0] {
    AXIS_XY  = 2'd0,
    AXIS_XZ  = 2'd1,
    AXIS_YZ  = 2'd2,
    AXIS_BAD = 2'd3
  } axis_t;

  typedef enum logic [2:0] {
    REG_AXIS   = 3'd0,
    REG_OFFSET = 3'd1,
    REG_LO_A   = 3'd2,
    REG_HI_A   = 3'd3,
    REG_LO_B   = 3'd4,
    REG_HI_B   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]         axis;
    logic signed [31:0] offset;
    logic signed [31:0] lo_a;
    logic signed [31:0] hi_a;
    logic signed [31:0] lo_b;
    logic signed [31:0] hi_b;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [31:0] oz;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] dz;
    logic signed [31:0] dmin;
    logic signed [31:0] dmax;
    logic [DIV_NW-1:0]  num_mag;
    logic [DIV_DW-1:0]  den_mag;
    logic               q_neg;
    logic               miss;
    logic               front;
  } item_t;

  function automatic logic [31:0] sat32(input logic [PT_W-1:0] x);
    logic ovf;
    ovf = (x[PT_W-1:31] != '0) && (x[PT_W-1:31] != '1);
    if (ovf) begin
      return x[PT_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    return x[31:0];
  endfunction

endpackage

>>> hdl/aarh_div.sv
// ----------------------------------------------------------------------------
// aarh_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module aarh_div import aarh_pkg::*; (
  input  logic              clk,
  input  logic [DIV_NW-1:0] num,
  input  logic [DIV_DW-1:0] den,
  output logic [DIV_NW-1:0] quo
);

  logic [DIV_DW-1:0] rem_r [DIV_NW];
  logic [DIV_NW-1:0] num_r [DIV_NW];
  logic [DIV_NW-1:0] quo_r [DIV_NW];
  logic [DIV_DW-1:0] den_r [DIV_NW];

  for (genvar i = 0; i < DIV_NW; i++) begin : g_stage
    logic [DIV_DW-1:0] rem_in;
    logic [DIV_DW-1:0] den_in;
    logic [DIV_NW-1:0] num_in;
    logic [DIV_NW-1:0] quo_in;
    logic [DIV_DW:0]   trial;
    logic [DIV_DW:0]   diff;
    logic              ge;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign den_in = den;
      assign num_in = num;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign den_in = den_r[i-1];
      assign num_in = num_r[i-1];
      assign quo_in = quo_r[i-1];
    end

    assign trial = {rem_in, num_in[DIV_NW-1]};
    assign diff  = trial - {1'b0, den_in};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      rem_r[i] <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
      num_r[i] <= {num_in[DIV_NW-2:0], 1'b0};
      quo_r[i] <= {quo_in[DIV_NW-2:0], ge};
      den_r[i] <= den_in;
    end
  end

  assign quo = quo_r[DIV_NW-1];

endmodule

>>> hdl/aarh_front.sv
// ----------------------------------------------------------------------------
// aarh_front
// Takes a ray, picks the normal axis and forms the plane distance operands.
// ----------------------------------------------------------------------------
module aarh_front import aarh_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  cfg_t        cfg,
  input  logic [31:0] in_origin_x,
  input  logic [31:0] in_origin_y,
  input  logic [31:0] in_origin_z,
  input  logic [31:0] in_dir_x,
  input  logic [31:0] in_dir_y,
  input  logic [31:0] in_dir_z,
  input  logic [31:0] in_dist_min,
  input  logic [31:0] in_dist_max,
  output logic        push,
  output item_t       item
);

  logic               valid_r;
  item_t              item_r;
  item_t              item_nxt;
  logic signed [31:0] org_n;
  logic signed [31:0] dir_n;
  logic signed [32:0] diff;
  logic signed [DIV_NW-1:0] num;
  logic [31:0]        den_abs;

  always_comb begin
    case (axis_t'(cfg.axis))
      AXIS_XY: begin
        org_n = in_origin_z;
        dir_n = in_dir_z;
      end
      AXIS_XZ: begin
        org_n = in_origin_y;
        dir_n = in_dir_y;
      end
      default: begin
        org_n = in_origin_x;
        dir_n = in_dir_x;
      end
    endcase
    diff    = {cfg.offset[31], cfg.offset} - {org_n[31], org_n};
    num     = {diff, {FRAC_BITS{1'b0}}};
    den_abs = dir_n[31] ? 32'(-dir_n) : dir_n;

    item_nxt.ox      = in_origin_x;
    item_nxt.oy      = in_origin_y;
    item_nxt.oz      = in_origin_z;
    item_nxt.dx      = in_dir_x;
    item_nxt.dy      = in_dir_y;
    item_nxt.dz      = in_dir_z;
    item_nxt.dmin    = in_dist_min;
    item_nxt.dmax    = in_dist_max;
    item_nxt.num_mag = num[DIV_NW-1] ? DIV_NW'(-num) : num;
    item_nxt.den_mag = {1'b0, den_abs};
    item_nxt.q_neg   = num[DIV_NW-1] ^ dir_n[31];
    item_nxt.miss    = (axis_t'(cfg.axis) == AXIS_BAD) || (dir_n == '0);
    item_nxt.front   = dir_n[31];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= accept;
    end
    if (accept) begin
      item_r <= item_nxt;
    end
  end

  assign push = valid_r;
  assign item = item_r;

endmodule

>>> hdl/aarh_fifo.sv
// ----------------------------------------------------------------------------
// aarh_fifo
// Two-entry queue between the front and the back of the hit test.
// ----------------------------------------------------------------------------
module aarh_fifo import aarh_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t wr_item,
  input  logic  pop_ready,
  output logic  pop,
  output item_t rd_item,
  output logic  full
);

  item_t      mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic [1:0] count_nxt;

  assign pop     = (count_r != 2'd0) && pop_ready;
  assign rd_item = mem_r[rd_ptr_r];
  assign full    = (count_r == 2'd2);

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

>>> hdl/aarh_back.sv
// ----------------------------------------------------------------------------
// aarh_back
// Divides for the distance, forms the hit point, tests the bounds and
// normalizes the in-plane coordinates.
// ----------------------------------------------------------------------------
module aarh_back import aarh_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  item_t       item,
  input  cfg_t        cfg,
  output logic        out_valid,
  output logic        out_hit,
  output logic [31:0] out_distance,
  output logic [16:0] out_coord_u,
  output logic [16:0] out_coord_v,
  output logic [31:0] out_point_x,
  output logic [31:0] out_point_y,
  output logic [31:0] out_point_z,
  output logic        out_front_face
);

  typedef struct packed {
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [31:0] oz;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] dz;
    logic signed [31:0] dmin;
    logic signed [31:0] dmax;
    logic               q_neg;
    logic               miss;
    logic               front;
  } side_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] t;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic        front;
    logic        zero_a;
    logic        zero_b;
  } res_t;

  // Distance divider and its side line.
  logic [DIV_NW-1:0] t_quo;
  logic              vld_d_r [DIV_LAT];
  side_t             side_d_r [DIV_LAT];
  side_t             sd;

  aarh_div u_div_t (
    .clk (clk),
    .num (item.num_mag),
    .den (item.den_mag),
    .quo (t_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_LAT; i++) begin
        vld_d_r[i] <= 1'b0;
      end
    end else begin
      vld_d_r[0] <= in_vld;
      for (int i = 1; i < DIV_LAT; i++) begin
        vld_d_r[i] <= vld_d_r[i-1];
      end
    end
    side_d_r[0] <= '{ox: item.ox, oy: item.oy, oz: item.oz, dx: item.dx, dy: item.dy,
                     dz: item.dz, dmin: item.dmin, dmax: item.dmax, q_neg: item.q_neg,
                     miss: item.miss, front: item.front};
    for (int i = 1; i < DIV_LAT; i++) begin
      side_d_r[i] <= side_d_r[i-1];
    end
  end

  assign sd = side_d_r[DIV_LAT-1];

  // Stage 1: signed distance and interval test.
  logic signed [T_W-1:0] t_full;
  logic                  s1_vld_r;
  logic                  s1_inr_r;
  logic signed [31:0]    s1_t_r;
  side_t                 s1_side_r;

  always_comb begin
    t_full = sd.q_neg ? -$signed({1'b0, t_quo}) : $signed({1'b0, t_quo});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= vld_d_r[DIV_LAT-1];
    end
    s1_inr_r  <= !sd.miss && (t_full >= T_W'(sd.dmin)) && (t_full <= T_W'(sd.dmax));
    s1_t_r    <= t_full[31:0];
    s1_side_r <= sd;
  end

  // Stage 2: products of distance and direction.
  logic               s2_vld_r;
  logic               s2_inr_r;
  logic signed [31:0] s2_t_r;
  logic signed [63:0] s2_px_r;
  logic signed [63:0] s2_py_r;
  logic signed [63:0] s2_pz_r;
  side_t              s2_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    s2_inr_r  <= s1_inr_r;
    s2_t_r    <= s1_t_r;
    s2_px_r   <= s1_t_r * s1_side_r.dx;
    s2_py_r   <= s1_t_r * s1_side_r.dy;
    s2_pz_r   <= s1_t_r * s1_side_r.dz;
    s2_side_r <= s1_side_r;
  end

  // Stage 3: hit point, product rounded toward minus infinity.
  logic                   s3_vld_r;
  logic                   s3_inr_r;
  logic signed [31:0]     s3_t_r;
  logic signed [PT_W-1:0] s3_x_r;
  logic signed [PT_W-1:0] s3_y_r;
  logic signed [PT_W-1:0] s3_z_r;
  logic                   s3_front_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
    s3_inr_r   <= s2_inr_r;
    s3_t_r     <= s2_t_r;
    s3_x_r     <= PT_W'(s2_side_r.ox) + PT_W'($signed(s2_px_r[63:FRAC_BITS]));
    s3_y_r     <= PT_W'(s2_side_r.oy) + PT_W'($signed(s2_py_r[63:FRAC_BITS]));
    s3_z_r     <= PT_W'(s2_side_r.oz) + PT_W'($signed(s2_pz_r[63:FRAC_BITS]));
    s3_front_r <= s2_side_r.front;
  end

  // Stage 4: bounds test and normalization operands.
  logic signed [PT_W-1:0] ca;
  logic signed [PT_W-1:0] cb;
  logic signed [PT_W-1:0] rel_a;
  logic signed [PT_W-1:0] rel_b;
  logic signed [32:0]     span_a;
  logic signed [32:0]     span_b;
  logic                   in_bounds;
  logic [DIV_NW-1:0]      num_a_r;
  logic [DIV_NW-1:0]      num_b_r;
  logic [DIV_DW-1:0]      den_a_r;
  logic [DIV_DW-1:0]      den_b_r;
  logic                   s4_vld_r;
  res_t                   s4_res_r;

  always_comb begin
    case (axis_t'(cfg.axis))
      AXIS_XY: begin
        ca = s3_x_r;
        cb = s3_y_r;
      end
      AXIS_XZ: begin
        ca = s3_x_r;
        cb = s3_z_r;
      end
      default: begin
        ca = s3_y_r;
        cb = s3_z_r;
      end
    endcase
    rel_a     = ca - PT_W'(cfg.lo_a);
    rel_b     = cb - PT_W'(cfg.lo_b);
    span_a    = 33'(cfg.hi_a) - 33'(cfg.lo_a);
    span_b    = 33'(cfg.hi_b) - 33'(cfg.lo_b);
    in_bounds = (ca >= PT_W'(cfg.lo_a)) && (ca <= PT_W'(cfg.hi_a)) &&
                (cb >= PT_W'(cfg.lo_b)) && (cb <= PT_W'(cfg.hi_b));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= s3_vld_r;
    end
    // On a hit the coordinate lies within its bounds, so the offsets are small.
    num_a_r         <= {rel_a[32:0], {UV_BITS{1'b0}}};
    num_b_r         <= {rel_b[32:0], {UV_BITS{1'b0}}};
    den_a_r         <= span_a;
    den_b_r         <= span_b;
    s4_res_r.hit    <= s3_inr_r && in_bounds;
    s4_res_r.t      <= s3_t_r;
    s4_res_r.px     <= sat32(s3_x_r);
    s4_res_r.py     <= sat32(s3_y_r);
    s4_res_r.pz     <= sat32(s3_z_r);
    s4_res_r.front  <= s3_front_r;
    s4_res_r.zero_a <= (span_a == '0);
    s4_res_r.zero_b <= (span_b == '0);
  end

  // Normalization dividers and their side line.
  logic [DIV_NW-1:0] u_quo;
  logic [DIV_NW-1:0] v_quo;
  logic              vld_e_r [DIV_LAT];
  res_t              res_e_r [DIV_LAT];
  res_t              re;

  aarh_div u_div_u (
    .clk (clk),
    .num (num_a_r),
    .den (den_a_r),
    .quo (u_quo)
  );

  aarh_div u_div_v (
    .clk (clk),
    .num (num_b_r),
    .den (den_b_r),
    .quo (v_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_LAT; i++) begin
        vld_e_r[i] <= 1'b0;
      end
    end else begin
      vld_e_r[0] <= s4_vld_r;
      for (int i = 1; i < DIV_LAT; i++) begin
        vld_e_r[i] <= vld_e_r[i-1];
      end
    end
    res_e_r[0] <= s4_res_r;
    for (int i = 1; i < DIV_LAT; i++) begin
      res_e_r[i] <= res_e_r[i-1];
    end
  end

  assign re = res_e_r[DIV_LAT-1];

  // Output register; a miss reports all fields as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld_e_r[DIV_LAT-1];
    end
    out_hit        <= re.hit;
    out_distance   <= re.hit ? re.t : '0;
    out_coord_u    <= (re.hit && !re.zero_a) ? u_quo[16:0] : '0;
    out_coord_v    <= (re.hit && !re.zero_b) ? v_quo[16:0] : '0;
    out_point_x    <= re.hit ? re.px : '0;
    out_point_y    <= re.hit ? re.py : '0;
    out_point_z    <= re.hit ? re.pz : '0;
    out_front_face <= re.hit && re.front;
  end

`ifndef SYNTH
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_distance == '0 && out_point_x == '0 &&
                              out_coord_u == '0 && !out_front_face)
    else $error("miss result carries nonzero fields");

  a_uv_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_coord_u <= 17'd65536 && out_coord_v <= 17'd65536)
    else $error("normalized coordinate above one");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    s4_vld_r |=> vld_e_r[0])
    else $error("item lost entering normalization");
`endif

endmodule

>>> hdl/axis_aligned_rect_ray_hit.sv
// ----------------------------------------------------------------------------
// axis_aligned_rect_ray_hit
// Ray versus axis-aligned rectangle intersection in signed Q16.16.
// ----------------------------------------------------------------------------
// A ray is taken on any cycle with start high and busy low, one per cycle.
// Its result appears on the out_ ports for one cycle with out_valid high,
// after the front register, the queue, two 49-stage pipelined dividers
// (distance, then u and v normalization) and the output register. The result
// cannot be held off, so capture it when out_valid is high. Configuration
// writes are always ready and must be made while no ray is in flight.
module axis_aligned_rect_ray_hit import aarh_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_origin_x,
  input  logic [31:0] in_origin_y,
  input  logic [31:0] in_origin_z,
  input  logic [31:0] in_dir_x,
  input  logic [31:0] in_dir_y,
  input  logic [31:0] in_dir_z,
  input  logic [31:0] in_dist_min,
  input  logic [31:0] in_dist_max,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        out_valid,
  output logic        out_hit,
  output logic [31:0] out_distance,
  output logic [16:0] out_coord_u,
  output logic [16:0] out_coord_v,
  output logic [31:0] out_point_x,
  output logic [31:0] out_point_y,
  output logic [31:0] out_point_z,
  output logic        out_front_face
);

  cfg_t  cfg_r;
  logic  accept;
  logic  push;
  item_t fr_item;
  logic  pop;
  item_t q_item;
  logic  full;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign busy      = full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.axis   <= AXIS_XY;
      cfg_r.offset <= '0;
      cfg_r.lo_a   <= '0;
      cfg_r.hi_a   <= 32'sd65536;
      cfg_r.lo_b   <= '0;
      cfg_r.hi_b   <= 32'sd65536;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_AXIS:   cfg_r.axis   <= cfg_data[1:0];
        REG_OFFSET: cfg_r.offset <= cfg_data;
        REG_LO_A:   cfg_r.lo_a   <= cfg_data;
        REG_HI_A:   cfg_r.hi_a   <= cfg_data;
        REG_LO_B:   cfg_r.lo_b   <= cfg_data;
        REG_HI_B:   cfg_r.hi_b   <= cfg_data;
        default: ;
      endcase
    end
  end

  aarh_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .cfg         (cfg_r),
    .in_origin_x (in_origin_x),
    .in_origin_y (in_origin_y),
    .in_origin_z (in_origin_z),
    .in_dir_x    (in_dir_x),
    .in_dir_y    (in_dir_y),
    .in_dir_z    (in_dir_z),
    .in_dist_min (in_dist_min),
    .in_dist_max (in_dist_max),
    .push        (push),
    .item        (fr_item)
  );

  aarh_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_item   (fr_item),
    .pop_ready (1'b1),
    .pop       (pop),
    .rd_item   (q_item),
    .full      (full)
  );

  aarh_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_vld         (pop),
    .item           (q_item),
    .cfg            (cfg_r),
    .out_valid      (out_valid),
    .out_hit        (out_hit),
    .out_distance   (out_distance),
    .out_coord_u    (out_coord_u),
    .out_coord_v    (out_coord_v),
    .out_point_x    (out_point_x),
    .out_point_y    (out_point_y),
    .out_point_z    (out_point_z),
    .out_front_face (out_front_face)
  );

endmodule
